// ===== sv/sv2seg_pkg.sv =====
// shared constants, types and the segment lookup for the signed value display core
// no dependencies

package sv2seg_pkg;

  localparam int NumW = 16;
  localparam int MagW = 14;
  localparam int SegW = 7;
  localparam int PtW  = 4;
  localparam int MaskW = 3;

  typedef logic signed [NumW-1:0] num_t;
  typedef logic [MagW-1:0]        mag_t;
  typedef logic [SegW-1:0]        seg_t;
  typedef logic [MaskW-1:0]       mask_t;
  typedef logic [PtW-1:0]         pt_t;
  typedef logic [3:0]             digit_t;

  localparam num_t SatHiIn  = 16'sd16000;
  localparam num_t SatHiVal = 16'sd15999;
  localparam num_t SatLoIn  = -16'sd1000;
  localparam num_t SatLoVal = -16'sd999;

  localparam seg_t SegMinus = 7'h40;

  // reciprocals, exact for magnitudes below 2**14
  localparam logic [15:0] Recip10   = 16'd52429;  // shift 19
  localparam logic [12:0] Recip100  = 13'd5243;   // shift 19
  localparam logic [14:0] Recip1000 = 15'd16778;  // shift 24

  function automatic seg_t hex_seg(input digit_t d);
    seg_t s;
    unique case (d)
      4'h0: s = 7'h3F;
      4'h1: s = 7'h06;
      4'h2: s = 7'h5B;
      4'h3: s = 7'h4F;
      4'h4: s = 7'h66;
      4'h5: s = 7'h6D;
      4'h6: s = 7'h7D;
      4'h7: s = 7'h07;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h6F;
      4'hA: s = 7'h77;
      4'hB: s = 7'h7C;
      4'hC: s = 7'h39;
      4'hD: s = 7'h5E;
      4'hE: s = 7'h79;
      default: s = 7'h71;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/sv2seg_if.sv =====
// valid/ready channel interfaces for the signed value display core
// depends on sv2seg_pkg

interface sv2seg_in_if import sv2seg_pkg::*; ();
  logic valid;
  logic ready;
  num_t number;
  logic show_sign;

  modport source (output valid, number, show_sign, input ready);
  modport sink (input valid, number, show_sign, output ready);
endinterface

interface sv2seg_out_if import sv2seg_pkg::*; ();
  logic valid;
  logic ready;
  seg_t seg_units;
  seg_t seg_tens;
  seg_t seg_hundreds;
  seg_t seg_top;
  pt_t  point_bits;

  modport source (output valid, seg_units, seg_tens, seg_hundreds, seg_top, point_bits,
                  input ready);
  modport sink (input valid, seg_units, seg_tens, seg_hundreds, seg_top, point_bits,
                output ready);
endinterface

interface sv2seg_cfg_if import sv2seg_pkg::*; ();
  logic  valid;
  logic  ready;
  mask_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/signed_value_to_seven_segment_core.sv =====
// signed value to four-digit seven-segment patterns, top level
// depends on sv2seg_pkg and the channel interfaces in sv2seg_if.sv
// an accepted word is registered in the input stage, then in the result stage, before it reaches the output
// throughput: one word per cycle while segments.ready is high, set by the two-register pipeline (input, result)
// reset: rst clears both pipeline valid flags and the point mask to zero
// config writes are always taken (ready held high)

module signed_value_to_seven_segment_core import sv2seg_pkg::*; (
  input logic         clk,
  input logic         rst,
  sv2seg_in_if.sink   value,
  sv2seg_cfg_if.sink  cfg,
  sv2seg_out_if.source segments
);

  // configuration register
  mask_t point_mask;

  // input stage
  logic  s1_valid;
  num_t  s1_number;
  logic  s1_show_sign;

  // result stage
  logic  out_valid;
  seg_t  out_units;
  seg_t  out_tens;
  seg_t  out_hundreds;
  seg_t  out_top;
  pt_t   out_points;

  logic  advance;
  logic  take;

  // datapath between the two stages
  logic        ovf_hi;
  logic        ovf_lo;
  num_t        sat;
  logic        neg;
  num_t        abs_val;
  mag_t        mag;
  logic [29:0] prod10;
  logic [26:0] prod100;
  logic [28:0] prod1000;
  logic [10:0] q10;
  logic [7:0]  q100;
  logic [4:0]  q1000;
  mag_t        units_w;
  logic [10:0] tens_w;
  logic [7:0]  hund_w;
  seg_t        top_next;
  seg_t        units_next;
  seg_t        tens_next;
  seg_t        hund_next;
  pt_t         points_next;

  // result register moves when empty or when the word is being taken
  assign advance     = !out_valid || segments.ready;
  assign value.ready = !s1_valid || advance;
  assign take        = value.valid && value.ready;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_mask <= '0;
    end else if (cfg.valid) begin
      point_mask <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (value.ready) begin
      s1_valid <= value.valid;
    end
  end

  // payload capture needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      s1_number    <= value.number;
      s1_show_sign <= value.show_sign;
    end
  end

  // saturate to -999..15999, overflow on either side
  always_comb begin
    ovf_hi = (s1_number >= SatHiIn);
    ovf_lo = (s1_number <= SatLoIn);
    if (ovf_hi) begin
      sat = SatHiVal;
    end else if (ovf_lo) begin
      sat = SatLoVal;
    end else begin
      sat = s1_number;
    end
    neg     = sat[NumW-1];
    abs_val = neg ? -sat : sat;
    mag     = abs_val[MagW-1:0];
  end

  // three independent reciprocal multiplies, then small corrections by ten
  always_comb begin
    prod10   = 30'(mag) * 30'(Recip10);
    prod100  = 27'(mag) * 27'(Recip100);
    prod1000 = 29'(mag) * 29'(Recip1000);
    q10      = prod10[29:19];
    q100     = prod100[26:19];
    q1000    = prod1000[28:24];
    units_w  = mag - 14'(q10) * 14'd10;
    tens_w   = q10 - 11'(q100) * 11'd10;
    hund_w   = q100 - 8'(q1000) * 8'd10;
  end

  // pattern lookup and points
  always_comb begin
    units_next = hex_seg(units_w[3:0]);
    tens_next  = hex_seg(tens_w[3:0]);
    hund_next  = hex_seg(hund_w[3:0]);
    if (neg && s1_show_sign) begin
      top_next = SegMinus;
    end else begin
      top_next = hex_seg(q1000[3:0]);
    end
    points_next = {ovf_hi || ovf_lo, point_mask};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_units    <= units_next;
      out_tens     <= tens_next;
      out_hundreds <= hund_next;
      out_top      <= top_next;
      out_points   <= points_next;
    end
  end

  assign segments.valid        = out_valid;
  assign segments.seg_units    = out_units;
  assign segments.seg_tens     = out_tens;
  assign segments.seg_hundreds = out_hundreds;
  assign segments.seg_top      = out_top;
  assign segments.point_bits   = out_points;

  // reciprocal digits stay decimal, thousands stay a hex digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (units_w < 14'd10) && (tens_w < 11'd10) && (hund_w < 8'd10)
                 && (q1000 < 5'd16))
    else $error("digit split out of range");

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  // an accepted word occupies the input stage next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    take |=> s1_valid)
    else $error("accepted word lost");

  // a stalled result keeps the input stage from being overwritten
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid && $stable(s1_number))
    else $error("input stage overwritten under stall");

endmodule
